/* rtl/assert_macros.svh */
// assertion macros for the frame allocator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// check sampled on the rising edge, switched off while reset is asserted
`define BFA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check sampled on every rising edge, reset included
`define BFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BFA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/bfa_pkg.sv */
// shared types, codes and defaults of the bitmap frame allocator
// no dependencies
`timescale 1ns / 1ps

package bfa_pkg;

	localparam int FRAME_W        = 12;
	localparam int CFG_W          = 13;
	localparam int STATUS_W       = 3;
	localparam int FIELD_FRAMES   = 4096;
	localparam int DEF_NUM_FRAMES = 4096;
	localparam int DEF_WORD_BITS  = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MAPPED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic               mode;
		logic [FRAME_W-1:0] page_frame;
		logic               is_kernel;
		logic               is_writeable;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  frame_out;
		logic                present;
		logic                writable;
		logic                user_access;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic                clr_step;
		logic                req_load;
		logic                scan_start;
		logic                check;
		logic                div;
		logic                fix;
		logic                free_write;
		logic                out_load;
		logic [STATUS_W-1:0] out_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic mode;
		logic page_zero;
		logic start_beyond;
		logic found;
		logic last_word;
		logic out_free;
	} sts_t;

endpackage

/* rtl/bfa_datapath.sv */
// bitmap memory, scan and free arithmetic, config and response registers
// depends on bfa_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfa_datapath #(
	parameter int NUM_FRAMES = bfa_pkg::DEF_NUM_FRAMES,
	parameter int WORD_BITS  = bfa_pkg::DEF_WORD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bfa_pkg::cmd_t                  cmd,
	output bfa_pkg::sts_t                  sts,
	input  bfa_pkg::req_t                  req,
	output bfa_pkg::rsp_t                  rsp,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	input  logic                           cfg_we,
	input  logic [bfa_pkg::CFG_W-1:0]      cfg_wdata
);
	import bfa_pkg::*;

	localparam int EFF_FRAMES = (NUM_FRAMES < FIELD_FRAMES) ? NUM_FRAMES : FIELD_FRAMES;
	localparam int MAP_WORDS  = (EFF_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int RSH        = 16;
	localparam int RECIP      = (1 << RSH) / WORD_BITS;
	localparam int RECIP_W    = $clog2(RECIP + 1);
	localparam int PROD_W     = FRAME_W + RECIP_W;

	localparam logic [CFG_W-1:0]   EFF_LIM  = CFG_W'(EFF_FRAMES);
	localparam logic [CFG_W-1:0]   WB_CFG   = CFG_W'(WORD_BITS);
	localparam logic [FRAME_W-1:0] WB_FRAME = FRAME_W'(WORD_BITS);

	logic [WORD_BITS-1:0] bitmap_mem [MAP_WORDS];

	logic [CFG_W-1:0]     cfg_q;
	req_t                 req_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;
	logic [WA_W-1:0]      clr_cnt_q;
	logic [WA_W-1:0]      hint_word_q;
	logic [CFG_W-1:0]     hint_base_q;
	logic [WA_W-1:0]      scan_word_q;
	logic [CFG_W-1:0]     scan_base_q;
	logic [WORD_BITS-1:0] rd_word_q;
	logic [FRAME_W-1:0]   alloc_frame_q;
	logic [FRAME_W-1:0]   q_est_q;
	logic [WA_W-1:0]      fr_word_q;
	logic [BIT_W-1:0]     fr_bit_q;
	logic [FRAME_W-1:0]   fr_base_q;
	logic                 fr_ok_q;

	logic [CFG_W-1:0]     lim;
	logic [CFG_W-1:0]     rem_lim;
	logic [WORD_BITS-1:0] vmask;
	logic [WORD_BITS-1:0] masked;
	logic [WORD_BITS-1:0] oh;
	logic [BIT_W-1:0]     hit_idx;
	logic                 found;
	logic                 last_word;
	logic [PROD_W-1:0]    prod;
	logic [FRAME_W-1:0]   base_est;
	logic [FRAME_W-1:0]   rem_est;
	logic                 corr;
	logic [FRAME_W-1:0]   q_fix;
	logic [FRAME_W-1:0]   bit_fix;
	logic [FRAME_W-1:0]   base_fix;
	logic                 rd_en;
	logic [WA_W-1:0]      rd_addr;
	logic                 mem_we;
	logic [WA_W-1:0]      mem_wa;
	logic [WORD_BITS-1:0] mem_wd;
	logic                 out_free;
	rsp_t                 rsp_d;

	// search limit and the valid bits of the word under test
	assign lim     = (cfg_q < EFF_LIM) ? cfg_q : EFF_LIM;
	assign rem_lim = lim - scan_base_q;
	assign last_word = rem_lim <= WB_CFG;

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			vmask[j] = CFG_W'(j) < rem_lim;
		end
	end

	// lowest clear bit as a one-hot vector, then its index
	assign masked = rd_word_q | ~vmask;
	assign oh     = ~masked & (masked + WORD_BITS'(1));
	assign found  = |oh;

	always_comb begin
		hit_idx = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (oh[j]) begin
				hit_idx = hit_idx | BIT_W'(j);
			end
		end
	end

	// frame to word and bit: reciprocal estimate, then one correction
	assign prod     = PROD_W'(req_q.page_frame) * PROD_W'(RECIP);
	assign base_est = q_est_q * WB_FRAME;
	assign rem_est  = req_q.page_frame - base_est;
	assign corr     = rem_est >= WB_FRAME;
	assign q_fix    = corr ? q_est_q + FRAME_W'(1) : q_est_q;
	assign bit_fix  = corr ? rem_est - WB_FRAME : rem_est;
	assign base_fix = corr ? base_est + WB_FRAME : base_est;

	// memory ports
	assign rd_en   = cmd.scan_start | (cmd.check & ~found & ~last_word) | cmd.fix;
	assign rd_addr = cmd.scan_start ? hint_word_q :
	                 cmd.fix        ? WA_W'(q_fix) : scan_word_q + WA_W'(1);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_cnt_q;
		mem_wd = '0;
		if (cmd.clr_step) begin
			mem_we = 1'b1;
		end else if (cmd.check && found) begin
			mem_we = 1'b1;
			mem_wa = scan_word_q;
			mem_wd = rd_word_q | oh;
		end else if (cmd.free_write && fr_ok_q) begin
			mem_we = 1'b1;
			mem_wa = fr_word_q;
			mem_wd = rd_word_q & ~(WORD_BITS'(1) << fr_bit_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_word_q <= bitmap_mem[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_q <= req;
		end
		if (cmd.div) begin
			q_est_q <= FRAME_W'(prod >> RSH);
		end
		if (cmd.fix) begin
			fr_word_q <= WA_W'(q_fix);
			fr_bit_q  <= BIT_W'(bit_fix);
			fr_base_q <= base_fix;
			fr_ok_q   <= CFG_W'(req_q.page_frame) < EFF_LIM;
		end
		if (cmd.check && found) begin
			alloc_frame_q <= scan_base_q[FRAME_W-1:0] + FRAME_W'(hit_idx);
		end
		if (cmd.scan_start) begin
			scan_word_q <= hint_word_q;
			scan_base_q <= hint_base_q;
		end else if (cmd.check && !found && !last_word) begin
			scan_word_q <= scan_word_q + WA_W'(1);
			scan_base_q <= scan_base_q + WB_CFG;
		end
	end

	// every word below the hint is fully used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_word_q <= '0;
			hint_base_q <= '0;
			clr_cnt_q   <= '0;
			cfg_q       <= CFG_RESET;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + WA_W'(1);
			end
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.check && found) begin
				hint_word_q <= scan_word_q;
				hint_base_q <= scan_base_q;
			end else if (cmd.free_write && fr_ok_q && fr_word_q < hint_word_q) begin
				hint_word_q <= fr_word_q;
				hint_base_q <= CFG_W'(fr_base_q);
			end
		end
	end

	// response register
	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		rsp_d        = '0;
		rsp_d.status = cmd.out_status;
		case (cmd.out_status)
			ST_ALLOCATED: begin
				rsp_d.frame_out   = alloc_frame_q;
				rsp_d.present     = 1'b1;
				rsp_d.writable    = req_q.is_writeable;
				rsp_d.user_access = ~req_q.is_kernel;
			end
			ST_MAPPED: begin
				rsp_d.frame_out = req_q.page_frame;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign sts.clr_last     = clr_cnt_q == WA_W'(MAP_WORDS - 1);
	assign sts.mode         = req_q.mode;
	assign sts.page_zero    = req_q.page_frame == '0;
	assign sts.start_beyond = hint_base_q >= lim;
	assign sts.found        = found;
	assign sts.last_word    = last_word;
	assign sts.out_free     = out_free;

	`BFA_ASSERT(a_hint_base, clk, arst_n, (hint_base_q == CFG_W'(hint_word_q * WORD_BITS)), "hint base out of step")
	`BFA_ASSERT(a_hit_onehot, clk, arst_n, (cmd.check && found) |-> $onehot(oh), "lowest clear bit not one-hot")
	`BFA_ASSERT(a_alloc_in_limit, clk, arst_n, (cmd.check && found) |=> ({1'b0, alloc_frame_q} < $past(lim)), "allocated frame beyond limit")

endmodule

/* rtl/bfa_ctrl.sv */
// sequencer of the frame allocator: clearing pass, scan and free steps
// depends on bfa_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output bfa_pkg::cmd_t cmd,
	input  bfa_pkg::sts_t sts
);
	import bfa_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECODE = 3'd2;
	localparam logic [2:0] S_CHECK  = 3'd3;
	localparam logic [2:0] S_FIX    = 3'd4;
	localparam logic [2:0] S_FWRITE = 3'd5;
	localparam logic [2:0] S_RESULT = 3'd6;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic [STATUS_W-1:0] st_q;
	logic [STATUS_W-1:0] st_d;

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.req_load = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!sts.mode) begin
					if (!sts.page_zero) begin
						st_d    = ST_MAPPED;
						state_d = S_RESULT;
					end else if (sts.start_beyond) begin
						st_d    = ST_FULL;
						state_d = S_RESULT;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_CHECK;
					end
				end else if (sts.page_zero) begin
					st_d    = ST_NOTHING;
					state_d = S_RESULT;
				end else begin
					cmd.div = 1'b1;
					state_d = S_FIX;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.found) begin
					st_d    = ST_ALLOCATED;
					state_d = S_RESULT;
				end else if (sts.last_word) begin
					st_d    = ST_FULL;
					state_d = S_RESULT;
				end
			end
			S_FIX: begin
				cmd.fix = 1'b1;
				state_d = S_FWRITE;
			end
			S_FWRITE: begin
				cmd.free_write = 1'b1;
				st_d           = ST_FREED;
				state_d        = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = st_q;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			st_q    <= ST_ALLOCATED;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	`BFA_ASSERT(a_accept_decode, clk, arst_n, (req_valid && req_ready) |=> (state_q == S_DECODE), "accepted request not decoded")
	`BFA_ASSERT(a_load_when_free, clk, arst_n, cmd.out_load |-> sts.out_free, "response loaded over a pending one")

endmodule

/* rtl/bitmap_frame_allocator_core.sv */
// First-fit physical frame allocator. One used bit per frame sits in a word
// memory of WORD_BITS-bit words inside bfa_datapath, sequenced by bfa_ctrl;
// types and codes come from bfa_pkg. After reset a clearing pass writes zero
// to each of the ceil(min(NUM_FRAMES,4096)/WORD_BITS) bitmap words (128 at
// the defaults), one word a cycle, and req_ready stays low until it is done;
// frames_in_use may be written meanwhile. An allocate request with
// page_frame zero scans words from a hint (the lowest word that may hold a
// free frame) at one word per cycle through the registered memory read port,
// sets the lowest clear bit below min(frames_in_use, NUM_FRAMES, 4096) and
// returns it; a nonzero page_frame is reported as already mapped. A free
// request clears the bit of a nonzero frame by a read-modify-write of its
// word. The response lands in an output register; the next request is taken
// once the sequencer is back in idle, even while that response still waits.
// States after acceptance: already mapped, nothing to free and a hint at the
// limit go from decode to result; a free passes decode, fix and free-write;
// an allocate passes decode and one check per word scanned (usually one word,
// since the hint skips full words); result waits for a free output register.
`timescale 1ns / 1ps

module bitmap_frame_allocator_core #(
	parameter int NUM_FRAMES = bfa_pkg::DEF_NUM_FRAMES,
	parameter int WORD_BITS  = bfa_pkg::DEF_WORD_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      req_valid,
	output logic                      req_ready,
	input  bfa_pkg::req_t             req,
	// response channel
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output bfa_pkg::rsp_t             rsp,
	// frames_in_use register, write only
	input  logic                      cfg_we,
	input  logic [bfa_pkg::CFG_W-1:0] cfg_wdata
);
	import bfa_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: clearing pass, request decode, scan loop, free steps
	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: bitmap memory, search hint, frame split, response register
	bfa_datapath #(
		.NUM_FRAMES (NUM_FRAMES),
		.WORD_BITS  (WORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

endmodule

/* dv/bitmap_frame_allocator_core_tb.sv */
// self-checking testbench for bitmap_frame_allocator_core: directed and random requests
// under random stalls on both channels, with a bit-per-frame predictor and an in-order checker
// depends on bfa_pkg and the allocator rtl only
`timescale 1ns / 1ps

module bitmap_frame_allocator_core_tb;
	import bfa_pkg::*;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_FREE    = 1'b1;
	localparam int   IDLE_LIMIT   = 3000;	// cycles with no request or response moving
	localparam int   HOLD_CYCLES  = 400;	// long response hold-off that backs the block up
	localparam int   REPORT_MAX   = 10;
	localparam int   RANDOM_ITEMS = 120;	// requests per random phase

	// predictor plus in-order check of page entry updates
	class frame_scoreboard;
		bit [FIELD_FRAMES-1:0] frame_used;
		int unsigned           frames_limit;
		rsp_t                  entry_updates_due[$];
		int unsigned           mismatches;

		function new();
			frame_used   = '0;
			frames_limit = CFG_RESET;
			mismatches   = 0;
		endfunction

		// work out the page entry update for an accepted request and queue it
		function void note_request(req_t r);
			rsp_t        upd;
			int unsigned lim;
			bit          found;
			upd   = '0;
			found = 1'b0;
			if (r.mode == MODE_ALLOC) begin
				if (r.page_frame != '0) begin
					upd.status    = ST_MAPPED;
					upd.frame_out = r.page_frame;
				end else begin
					// first fit below the smallest of the limit, the frame count and the field range
					lim = frames_limit;
					if (lim > FIELD_FRAMES)
						lim = FIELD_FRAMES;
					if (lim > DEF_NUM_FRAMES)
						lim = DEF_NUM_FRAMES;
					for (int unsigned f = 0; f < lim && !found; f++) begin
						if (!frame_used[f]) begin
							found            = 1'b1;
							frame_used[f]    = 1'b1;
							upd.status       = ST_ALLOCATED;
							upd.frame_out    = f[FRAME_W-1:0];
							upd.present      = 1'b1;
							upd.writable     = r.is_writeable;
							upd.user_access  = ~r.is_kernel;
						end
					end
					if (!found)
						upd.status = ST_FULL;
				end
			end else begin
				if (r.page_frame == '0) begin
					upd.status = ST_NOTHING;
				end else begin
					// a 12-bit frame is always inside the bitmap, so the bit is always cleared
					frame_used[r.page_frame] = 1'b0;
					upd.status = ST_FREED;
				end
			end
			entry_updates_due.push_back(upd);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (entry_updates_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: response with none due: status %0d frame %03h p %b w %b u %b",
						$realtime, got.status, got.frame_out, got.present, got.writable,
						got.user_access);
				return;
			end
			want = entry_updates_due.pop_front();
			if (got.status !== want.status || got.frame_out !== want.frame_out ||
				got.present !== want.present || got.writable !== want.writable ||
				got.user_access !== want.user_access) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: got status %0d frame %03h p %b w %b u %b, wanted status %0d frame %03h p %b w %b u %b",
						$realtime, got.status, got.frame_out, got.present, got.writable,
						got.user_access, want.status, want.frame_out, want.present,
						want.writable, want.user_access);
			end
		endfunction

		// a random frame now marked used, preferably one below the limit; 0 if none
		function int unsigned pick_used(bit below_limit);
			int unsigned all_q[$];
			int unsigned low_q[$];
			for (int unsigned f = 1; f < FIELD_FRAMES; f++) begin
				if (frame_used[f]) begin
					all_q.push_back(f);
					if (f < frames_limit)
						low_q.push_back(f);
				end
			end
			if (below_limit && low_q.size() != 0)
				return low_q[$urandom_range(0, low_q.size() - 1)];
			if (all_q.size() != 0)
				return all_q[$urandom_range(0, all_q.size() - 1)];
			return 0;
		endfunction
	endclass

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req       = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_t              rsp;
	logic              cfg_we    = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;

	frame_scoreboard   sb = new();
	bit                sender_gaps_on = 1'b1;
	int                hold_request   = 0;
	bit                holding        = 1'b0;

	bitmap_frame_allocator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ends the run if nothing moves on either channel for too long
	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("bitmap_frame_allocator_core regression: fail");
		$finish;
	end

	// response side: random stalls, long ready stretches, and a long hold-off on demand
	initial begin
		int pick;
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				holding = 1'b1;
				rsp_ready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
				holding = 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					rsp_ready <= 1'b1;
					repeat ($urandom_range(30, 120)) @(posedge clk);
				end else if (pick < 60) begin
					rsp_ready <= 1'b1;
					@(posedge clk);
				end else if (pick < 90) begin
					rsp_ready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else if (pick < 98) begin
					rsp_ready <= 1'b0;
					repeat ($urandom_range(4, 12)) @(posedge clk);
				end else begin
					rsp_ready <= 1'b0;
					repeat ($urandom_range(20, 60)) @(posedge clk);
				end
			end
		end
	end

	// response check, sampled on the edge that completes the handshake
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
	end

	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t make_req(logic m, int unsigned page, logic kern, logic wr);
		req_t r;
		r.mode         = m;
		r.page_frame   = page[FRAME_W-1:0];
		r.is_kernel    = kern;
		r.is_writeable = wr;
		return r;
	endfunction

	// mostly allocations and frees of frames really in use, the rest noise
	function automatic req_t random_request();
		int          pick;
		int unsigned f;
		logic        kern;
		logic        wr;
		kern = $urandom_range(0, 1);
		wr   = $urandom_range(0, 1);
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return make_req(MODE_ALLOC, 0, kern, wr);
		if (pick < 78) begin
			f = sb.pick_used($urandom_range(0, 9) < 7);
			if (f == 0)
				f = $urandom_range(1, FIELD_FRAMES - 1);
			return make_req(MODE_FREE, f, kern, wr);
		end
		if (pick < 86)
			return make_req(MODE_ALLOC, $urandom_range(1, FIELD_FRAMES - 1), kern, wr);
		if (pick < 90)
			return make_req(MODE_FREE, 0, kern, wr);
		return make_req(MODE_FREE, $urandom_range(1, FIELD_FRAMES - 1), kern, wr);
	endfunction

	// offer one request, hold it until taken, then maybe leave a gap
	task automatic send_req(input req_t r);
		int gap;
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_request(r);
		gap = sender_gaps_on ? idle_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait until every due update has come back
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.entry_updates_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_frames(input int unsigned limit);
		cfg_we    <= 1'b1;
		cfg_wdata <= limit[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.frames_limit = limit;
	endtask

	initial begin
		int unsigned phase_limits[10];
		int          items;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset limit: first fit, flag mapping, frame zero
		send_req(make_req(MODE_ALLOC, 0, 1'b0, 1'b1));
		send_req(make_req(MODE_ALLOC, 0, 1'b1, 1'b0));
		send_req(make_req(MODE_ALLOC, 0, 1'b1, 1'b1));
		send_req(make_req(MODE_ALLOC, 0, 1'b0, 1'b0));
		// already mapped, all-ones and lowest nonzero frame
		send_req(make_req(MODE_ALLOC, 12'hFFF, 1'b1, 1'b1));
		send_req(make_req(MODE_ALLOC, 1, 1'b0, 1'b0));
		// nothing to free
		send_req(make_req(MODE_FREE, 0, 1'b1, 1'b1));
		// free then double free, then the hole is refilled
		send_req(make_req(MODE_FREE, 2, 1'b0, 1'b0));
		send_req(make_req(MODE_FREE, 2, 1'b1, 1'b0));
		send_req(make_req(MODE_ALLOC, 0, 1'b1, 1'b1));
		// frees of frames never handed out
		send_req(make_req(MODE_FREE, 12'hFFF, 1'b0, 1'b1));
		send_req(make_req(MODE_FREE, 12'h800, 1'b1, 1'b1));

		// zero frames managed: nothing is searched, and a free still clears
		settle();
		write_frames(0);
		send_req(make_req(MODE_ALLOC, 0, 1'b0, 1'b1));
		send_req(make_req(MODE_FREE, 3, 1'b0, 1'b0));

		// one frame managed and frame 0 already in use
		settle();
		write_frames(1);
		send_req(make_req(MODE_ALLOC, 0, 1'b1, 1'b0));

		// register maximum, search capped by the frame field
		settle();
		write_frames(8191);
		send_req(make_req(MODE_ALLOC, 0, 1'b0, 1'b1));
		send_req(make_req(MODE_ALLOC, 0, 1'b1, 1'b1));

		// small pool runs dry, free beyond the limit, refill
		settle();
		write_frames(5);
		send_req(make_req(MODE_ALLOC, 0, 1'b0, 1'b0));
		send_req(make_req(MODE_FREE, 9, 1'b1, 1'b0));
		send_req(make_req(MODE_FREE, 4, 1'b0, 1'b1));
		send_req(make_req(MODE_ALLOC, 0, 1'b0, 1'b1));
		send_req(make_req(MODE_ALLOC, 0, 1'b1, 1'b0));

		// random phases over a spread of limits, the extremes among them
		phase_limits = '{4096, 33, 1, 8191, 40, 0, 64, 0, 4095, 0};
		phase_limits[7] = $urandom_range(2, 4096);
		phase_limits[9] = $urandom_range(1, 200);
		foreach (phase_limits[p]) begin
			settle();
			write_frames(phase_limits[p]);
			sender_gaps_on = ($urandom_range(0, 2) != 0);
			items = (phase_limits[p] == 0) ? 20 : RANDOM_ITEMS;
			if (p == 1) begin
				// hold responses back while requests keep coming, so the block fills up
				hold_request = HOLD_CYCLES;
				wait (holding);
				sender_gaps_on = 1'b0;
				repeat (24) send_req(random_request());
				sender_gaps_on = 1'b1;
				items -= 24;
			end
			for (int i = 0; i < items; i++) begin
				// one pause in the middle with the block allowed to empty completely
				if (p == 4 && i == items / 2)
					settle();
				send_req(random_request());
			end
		end

		settle();
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.entry_updates_due.size() == 0)
			$display("bitmap_frame_allocator_core regression: pass");
		else
			$display("bitmap_frame_allocator_core regression: fail");
		$finish;
	end

endmodule
